[rtl/frc_pkg.sv]
package frc_pkg;

    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

endpackage

[rtl/fifo_replacement_cache.sv]
// Fully associative cache of key and handle pairs with first-in, first-out
// replacement. Each beat on the input channel is a lookup or an insert and
// yields exactly one result beat. A beat is held in an input register, then a
// single pass compares its key against every valid entry in parallel, updates
// the entries and fills the result register, so one beat is taken every cycle
// when the output is not stalled, and its result is presented from the result
// register. The capacity register may be written only while the block is idle;
// zero acts as one and values above MAX_ENTRIES act as MAX_ENTRIES. The valid
// marks clear at reset, so no clearing pass is needed.
module fifo_replacement_cache #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [63:0] i_key,
    input  logic [31:0] i_handle_in,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [31:0] o_handle_out,
    output logic        o_inserted
);

    localparam int unsigned SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W  = (CNT_W > frc_pkg::CAP_W) ? CNT_W : frc_pkg::CAP_W;
    localparam int unsigned SUM_W  = CNT_W + 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ENTRIES - 1);
    localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_ENTRIES);
    localparam logic [SUM_W-1:0]  MAX_SUM   = SUM_W'(MAX_ENTRIES);

    logic [frc_pkg::CAP_W-1:0] r_capacity;

    logic                   r_in_valid;
    frc_pkg::t_op           r_in_op;
    logic [63:0]            r_in_key;
    logic [31:0]            r_in_handle;

    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [31:0]            r_out_handle;
    logic                   r_out_inserted;

    logic [63:0]            r_keys    [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] r_handles [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [SLOT_W-1:0]      r_oldest;
    logic [CNT_W-1:0]       r_count;

    logic [MAX_ENTRIES-1:0] n_valid;
    logic [SLOT_W-1:0]      n_oldest;
    logic [CNT_W-1:0]       n_count;

    logic                   w_can_out;
    logic                   w_fire;
    logic [MAX_ENTRIES-1:0] w_match;
    logic                   w_any_match;
    logic [HANDLE_BITS-1:0] w_sel_handle;
    logic [63:0]            w_sel_ext;
    logic [63:0]            w_new_ext;
    logic [CMP_W-1:0]       w_cap_raw;
    logic [CMP_W-1:0]       w_eff_cap;
    logic                   w_do_insert;
    logic                   w_evict;
    logic [SLOT_W-1:0]      w_oldest_adv;
    logic [CNT_W-1:0]       w_count_adv;
    logic [SUM_W-1:0]       w_sum;
    logic [SUM_W-1:0]       w_wr_sum;
    logic [SLOT_W-1:0]      w_wr_slot;

    assign o_cfg_ready  = 1'b1;
    assign w_can_out    = !r_out_valid || !i_out_stall;
    assign w_fire       = r_in_valid && w_can_out;
    assign o_in_stall   = r_in_valid && !w_can_out;

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_handle_out = r_out_handle;
    assign o_inserted   = r_out_inserted;

    always_comb begin
        w_sel_handle = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_keys[i] == r_in_key);
            if (w_match[i]) begin
                w_sel_handle = w_sel_handle | r_handles[i];
            end
        end
    end

    assign w_any_match = |w_match;
    assign w_sel_ext   = 64'(w_sel_handle);
    assign w_new_ext   = {32'b0, r_in_handle};

    assign w_cap_raw = CMP_W'(r_capacity);
    always_comb begin
        priority if (w_cap_raw == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_raw > MAX_CMP) begin
            w_eff_cap = MAX_CMP;
        end else begin
            w_eff_cap = w_cap_raw;
        end
    end

    assign w_do_insert = w_fire && (r_in_op == frc_pkg::OP_INSERT) && !w_any_match;
    assign w_evict     = (CMP_W'(r_count) >= w_eff_cap) && (r_count != '0);

    always_comb begin
        w_oldest_adv = (r_oldest == LAST_SLOT) ? '0 : r_oldest + SLOT_W'(1);
        w_count_adv  = r_count - CNT_W'(1);
        n_valid      = r_valid;
        n_oldest     = r_oldest;
        n_count      = r_count;
        if (w_do_insert && w_evict) begin
            n_valid[r_oldest] = 1'b0;
            n_oldest          = w_oldest_adv;
            n_count           = w_count_adv;
        end
        w_sum     = SUM_W'(n_oldest) + SUM_W'(n_count);
        w_wr_sum  = (w_sum >= MAX_SUM) ? (w_sum - MAX_SUM) : w_sum;
        w_wr_slot = w_wr_sum[SLOT_W-1:0];
        if (w_do_insert) begin
            n_valid[w_wr_slot] = 1'b1;
            n_count            = n_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= frc_pkg::CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_can_out) begin
                r_out_valid <= r_in_valid;
            end
            r_valid  <= n_valid;
            r_oldest <= n_oldest;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_op     <= frc_pkg::t_op'(i_operation);
            r_in_key    <= i_key;
            r_in_handle <= i_handle_in;
        end
        if (w_fire) begin
            r_out_hit      <= (r_in_op == frc_pkg::OP_LOOKUP) && w_any_match;
            r_out_handle   <= ((r_in_op == frc_pkg::OP_LOOKUP) && w_any_match)
                              ? w_sel_ext[31:0] : 32'b0;
            r_out_inserted <= (r_in_op == frc_pkg::OP_INSERT) && !w_any_match;
        end
        if (w_do_insert) begin
            r_keys[w_wr_slot]    <= r_in_key;
            r_handles[w_wr_slot] <= w_new_ext[HANDLE_BITS-1:0];
        end
    end

endmodule
